// ----- sv/ppgc_pkg.sv -----
// ppgc_pkg: shared codes and types for the packed pixel gamma converter
// no dependencies; imported by the top level
`default_nettype none

package ppgc_pkg;

  // pixel format register codes
  typedef logic [1:0] pix_fmt_t;
  localparam pix_fmt_t FMT_12BPP = 2'd0;
  localparam pix_fmt_t FMT_16BPP = 2'd1;
  localparam pix_fmt_t FMT_18BPP = 2'd2;
  localparam pix_fmt_t FMT_24BPP = 2'd3;
  localparam pix_fmt_t FMT_RESET = FMT_16BPP;

  // request command codes
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;

  // raw table indices before widening to the table address
  localparam int IDX_W = 6;
  typedef logic [IDX_W-1:0] tbl_idx_t;

  typedef struct packed {
    tbl_idx_t r;
    tbl_idx_t g;
    tbl_idx_t b;
  } idx_set_t;

  // cut one packed word into red, green and blue table indices
  function automatic idx_set_t split_pixel(input pix_fmt_t fmt, input logic [23:0] w);
    idx_set_t s;
    s = '0;
    unique case (fmt)
      FMT_12BPP: begin
        s.r = {2'b00, w[15:12]};
        s.g = {2'b00, w[10:7]};
        s.b = {2'b00, w[4:1]};
      end
      FMT_16BPP: begin
        s.r = {1'b0, w[15:11]};
        s.g = w[10:5];
        s.b = {1'b0, w[4:0]};
      end
      FMT_18BPP: begin
        s.r = w[17:12];
        s.g = w[11:6];
        s.b = w[5:0];
      end
      default: begin
        s = '0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/packed_pixel_gamma_converter_unit.sv -----
// packed_pixel_gamma_converter_unit: top level of the pixel gamma converter
// depends on ppgc_pkg and ppgc_ram
//
// Usage:
//   The input channel (in_valid / in_stall) carries requests: cmd 0 converts
//   pixel_word under the current pixel_format, cmd 1 writes entry_value into
//   gamma table entry entry_index. Only converts give a result on the output
//   channel (out_valid / out_stall) as red_out, green_out and blue_out.
//   pixel_format is written through cfg_write / cfg_data while idle.
// Pipeline:
//   one request per cycle sustained while in_stall is low. The gamma ram
//   read registers at acceptance, and byte selection then loads the output
//   register from the ram stage when out_stall allows. The three colour
//   bytes sit in three ram copies, so one pixel reads all three.
// Reset:
//   rst clears the pipeline, sets pixel_format to 16bpp and clears one valid
//   flop per table entry; an unwritten entry reads as zero. No clearing pass.
// Stall:
//   out_stall holds the output register; the ram stage behind it still
//   fills, and in_stall rises only when both stages hold a pixel.
`default_nettype none

module packed_pixel_gamma_converter_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire ppgc_pkg::pix_fmt_t    cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic [23:0]           pixel_word,
  input  wire ppgc_pkg::tbl_idx_t    entry_index,
  input  wire logic [23:0]           entry_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out
);

  import ppgc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // configuration register
  pix_fmt_t pixel_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RESET;
    end else if (cfg_write) begin
      pixel_format <= cfg_data;
    end
  end

  // handshake and stage control
  logic in_fire;
  logic out_move;
  logic s1_valid;
  logic s1_pass;
  logic s1_move;
  logic tbl_wr;
  logic px_rd;

  assign out_move = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_move;
  assign in_stall = s1_valid && !out_move;
  assign in_fire  = in_valid && !in_stall;
  assign tbl_wr   = in_fire && (cmd == CMD_WRITE);
  assign px_rd    = in_fire && (cmd == CMD_CONVERT);

  // index extraction and address widening
  idx_set_t        idx;
  logic [AW-1:0]   addr_r;
  logic [AW-1:0]   addr_g;
  logic [AW-1:0]   addr_b;
  logic [AW-1:0]   addr_w;

  assign idx    = split_pixel(pixel_format, pixel_word);
  assign addr_r = AW'(idx.r);
  assign addr_g = AW'(idx.g);
  assign addr_b = AW'(idx.b);
  assign addr_w = AW'(entry_index);

  // gamma table, one copy per colour byte
  logic [7:0] ram_r;
  logic [7:0] ram_g;
  logic [7:0] ram_b;

  ppgc_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_r (
    .clk   (clk),
    .we    (tbl_wr),
    .waddr (addr_w),
    .wdata (entry_value[23:16]),
    .re    (px_rd),
    .raddr (addr_r),
    .rdata (ram_r)
  );

  ppgc_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_g (
    .clk   (clk),
    .we    (tbl_wr),
    .waddr (addr_w),
    .wdata (entry_value[15:8]),
    .re    (px_rd),
    .raddr (addr_g),
    .rdata (ram_g)
  );

  ppgc_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (tbl_wr),
    .waddr (addr_w),
    .wdata (entry_value[7:0]),
    .re    (px_rd),
    .raddr (addr_b),
    .rdata (ram_b)
  );

  // per-entry written flags, cleared at reset
  logic [TABLE_DEPTH-1:0] entry_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
    end else if (tbl_wr) begin
      entry_ok[addr_w] <= 1'b1;
    end
  end

  // ram stage: control, flags sampled with the read, passthrough bytes
  logic        s1_ok_r;
  logic        s1_ok_g;
  logic        s1_ok_b;
  logic [23:0] s1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire || s1_move) begin
      s1_valid <= px_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (px_rd) begin
      s1_pass <= (pixel_format == FMT_24BPP);
      s1_ok_r <= entry_ok[addr_r];
      s1_ok_g <= entry_ok[addr_g];
      s1_ok_b <= entry_ok[addr_b];
      s1_word <= pixel_word;
    end
  end

  // byte selection
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  always_comb begin
    if (s1_pass) begin
      red_next   = s1_word[23:16];
      green_next = s1_word[15:8];
      blue_next  = s1_word[7:0];
    end else begin
      red_next   = s1_ok_r ? ram_r : 8'd0;
      green_next = s1_ok_g ? ram_g : 8'd0;
      blue_next  = s1_ok_b ? ram_b : 8'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      red_out   <= red_next;
      green_out <= green_next;
      blue_out  <= blue_next;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (tbl_wr && !s1_valid) |=> !s1_valid)
    else $error("table write produced a pipeline entry");

  a_pass_bytes: assert property (@(posedge clk) disable iff (rst)
    (px_rd && (pixel_format == FMT_24BPP)) |=>
      (s1_valid && s1_pass && (s1_word == $past(pixel_word))))
    else $error("passthrough pixel lost its bytes");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (entry_ok == '0 && !s1_valid && !out_valid))
    else $error("reset left table flags or pipeline set");

endmodule

`default_nettype wire

// ----- sv/ppgc_ram.sv -----
// ppgc_ram: generic single write port, single read port ram
// registered read with read enable; no dependencies
`default_nettype none

module ppgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for packed_pixel_gamma_converter_unit: a directed table, then random requests
// under every pixel format, checked against a gamma lookup predictor
// depends on ppgc_pkg and the converter rtl
`timescale 1ns / 100ps

module testbench;
  import ppgc_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 12;
  localparam int DRAIN_CYCLES     = 6;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int PHASES           = 6;
  localparam int PHASE_REQUESTS   = 250;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef enum logic { ROW_REQUEST, ROW_FORMAT } row_kind_t;
  typedef enum logic [1:0] { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC } stall_mode_t;

  // one line of the directed table; rgb is used only when known is set
  typedef struct packed {
    row_kind_t   kind;
    pix_fmt_t    fmt;
    logic        c;
    logic [23:0] word;
    tbl_idx_t    idx;
    logic [23:0] val;
    logic        known;
    rgb_t        rgb;
  } stim_row_t;

  typedef struct packed {
    logic known;
    rgb_t rgb;
  } hint_t;

  function automatic stim_row_t format_row(input pix_fmt_t f);
    stim_row_t row;
    row = '0;
    row.kind = ROW_FORMAT;
    row.fmt = f;
    return row;
  endfunction

  function automatic stim_row_t write_row(input tbl_idx_t i, input logic [23:0] v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.c = CMD_WRITE;
    row.idx = i;
    row.val = v;
    return row;
  endfunction

  function automatic stim_row_t convert_row(input logic [23:0] w);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.c = CMD_CONVERT;
    row.word = w;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [23:0] w, input logic [23:0] rgb);
    stim_row_t row;
    row = convert_row(w);
    row.known = 1'b1;
    row.rgb = rgb;
    return row;
  endfunction

  // directed requests; format starts at 16bpp after reset
  localparam int DIRECTED_COUNT = 26;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    known_row(24'hFFFFFF, 24'h000000),   // table cleared by reset
    write_row(6'd0, 24'hFFFFFF),
    write_row(6'd63, 24'h123456),
    write_row(6'd31, 24'hA5C3E7),
    known_row(24'h000000, 24'hFFFFFF),
    known_row(24'hFFFFFF, 24'hA534E7),   // top indices of 5-6-5
    known_row(24'hFF0000, 24'hFFFFFF),   // upper byte ignored
    convert_row(24'h00F81F),
    format_row(FMT_12BPP),
    known_row(24'hFF0861, 24'hFFFFFF),   // gap bits between 4-bit fields ignored
    convert_row(24'h00FFFF),
    write_row(6'd15, 24'h0F0F0F),
    convert_row(24'h00F79E),
    format_row(FMT_18BPP),
    known_row(24'hFFFFFF, 24'h123456),
    known_row(24'hFC0000, 24'hFFFFFF),   // bits 18 and up ignored
    write_row(6'd5, 24'h010203),
    known_row(24'h005145, 24'h010203),   // read right behind its write
    write_row(6'd5, 24'h0A0B0C),
    known_row(24'h005145, 24'h0A0B0C),   // overwrite of a live entry
    format_row(FMT_24BPP),
    known_row(24'hABCDEF, 24'hABCDEF),
    known_row(24'h000000, 24'h000000),
    known_row(24'hFFFFFF, 24'hFFFFFF),
    format_row(FMT_16BPP),
    convert_row(24'h0007E0)
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  pix_fmt_t    cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [23:0] pixel_word;
  tbl_idx_t    entry_index;
  logic [23:0] entry_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  // predictor state
  logic [23:0] gamma_copy [64];
  pix_fmt_t    fmt_copy;
  rgb_t        expected_rgb [$];
  hint_t       hint_q [$];

  int  fail_count;
  int  convert_count;
  int  write_count;
  int  result_count;
  int  cycle_count;
  bit  formats_seen [4];

  packed_pixel_gamma_converter_unit #(
    .TABLE_DEPTH(64)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .pixel_word (pixel_word),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // gamma lookup of one pixel under format f
  function automatic rgb_t gamma_lookup(input pix_fmt_t f, input logic [23:0] w);
    tbl_idx_t ri;
    tbl_idx_t gi;
    tbl_idx_t bi;
    rgb_t     px;
    if (f == FMT_24BPP) begin
      return rgb_t'(w);
    end
    case (f)
      FMT_12BPP: begin
        ri = tbl_idx_t'(w[15:12]);
        gi = tbl_idx_t'(w[10:7]);
        bi = tbl_idx_t'(w[4:1]);
      end
      FMT_16BPP: begin
        ri = tbl_idx_t'(w[15:11]);
        gi = w[10:5];
        bi = tbl_idx_t'(w[4:0]);
      end
      default: begin
        ri = w[17:12];
        gi = w[11:6];
        bi = w[5:0];
      end
    endcase
    px.r = gamma_copy[ri][23:16];
    px.g = gamma_copy[gi][15:8];
    px.b = gamma_copy[bi][7:0];
    return px;
  endfunction

  // track config and accepted requests, queue the colours each convert should give
  always @(posedge clk) begin
    hint_t hint;
    if (rst) begin
      fmt_copy = FMT_RESET;
      foreach (gamma_copy[i]) gamma_copy[i] = '0;
    end else begin
      if (cfg_write) begin
        fmt_copy = cfg_data;
      end
      if (in_valid && !in_stall) begin
        hint = '0;
        if (hint_q.size() != 0) begin
          hint = hint_q.pop_front();
        end
        if (cmd == CMD_WRITE) begin
          gamma_copy[entry_index] = entry_value;
          write_count++;
        end else begin
          expected_rgb.push_back(hint.known ? hint.rgb : gamma_lookup(fmt_copy, pixel_word));
          formats_seen[fmt_copy] = 1'b1;
          convert_count++;
        end
      end
    end
  end

  // compare each delivered pixel with the oldest expectation
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rgb.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES) begin
          $display("unexpected pixel r=%02h g=%02h b=%02h at cycle %0d",
                   red_out, green_out, blue_out, cycle_count);
        end
      end else begin
        want = expected_rgb.pop_front();
        result_count++;
        if (red_out !== want.r || green_out !== want.g || blue_out !== want.b) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES) begin
            $display("pixel %0d mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                     result_count, want.r, want.g, want.b, red_out, green_out, blue_out);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending",
               cycle_count, expected_rgb.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure in stretches of different character
  initial begin
    stall_mode_t mode;
    int          span;
    int          tick;
    out_stall <= 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // drive one request and hold it until taken
  task automatic send_request(input logic c, input logic [23:0] w, input tbl_idx_t ei,
                              input logic [23:0] ev, input hint_t hint);
    hint_q.push_back(hint);
    in_valid    <= 1'b1;
    cmd         <= c;
    pixel_word  <= w;
    entry_index <= ei;
    entry_value <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and let every pending pixel and any table write finish
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input pix_fmt_t f);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    stim_row_t   row;
    hint_t       hint;
    hint_t       no_hint;
    pix_fmt_t    phase_fmt;
    logic [23:0] word;
    tbl_idx_t    last_idx;
    bit          last_write;
    bit          steady;
    int          sent;
    int          burst;

    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_data    <= FMT_RESET;
    in_valid    <= 1'b0;
    cmd         <= CMD_CONVERT;
    pixel_word  <= '0;
    entry_index <= '0;
    entry_value <= '0;
    no_hint = '0;
    last_idx = '0;
    last_write = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int n = 0; n < DIRECTED_COUNT; n++) begin
      row = DIRECTED_ROWS[n];
      if (row.kind == ROW_FORMAT) begin
        set_format(row.fmt);
      end else begin
        hint.known = row.known;
        hint.rgb = row.rgb;
        if (row.c == CMD_WRITE) begin
          send_request(CMD_WRITE, 24'($urandom), row.idx, row.val, hint);
        end else begin
          send_request(CMD_CONVERT, row.word, tbl_idx_t'($urandom), 24'($urandom), hint);
        end
        if ($urandom_range(0, 2) == 0) begin
          hold_off($urandom_range(1, 3));
        end
      end
    end

    // random phases, one pixel format each
    for (int p = 0; p < PHASES; p++) begin
      phase_fmt = (p < 4) ? pix_fmt_t'(p) : pix_fmt_t'($urandom_range(0, 3));
      set_format(phase_fmt);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        burst = $urandom_range(1, 24);
        steady = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < burst && sent < PHASE_REQUESTS; k++) begin
          // sender waits for a fully drained pipeline once mid-run
          if (p == 2 && sent == PHASE_REQUESTS / 2) begin
            wait_for_results();
          end
          if ($urandom_range(0, 3) == 0) begin
            last_idx = tbl_idx_t'($urandom);
            send_request(CMD_WRITE, 24'($urandom), last_idx, 24'($urandom), no_hint);
            last_write = 1'b1;
          end else begin
            word = 24'($urandom);
            if ($urandom_range(0, 9) == 0) begin
              word = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
            end
            // aim all three components at the entry just written, index cut to field width in 12bpp and 16bpp
            if (last_write && $urandom_range(0, 2) == 0) begin
              case (phase_fmt)
                FMT_12BPP: begin
                  word[15:12] = last_idx[3:0];
                  word[10:7]  = last_idx[3:0];
                  word[4:1]   = last_idx[3:0];
                end
                FMT_16BPP: begin
                  word[15:11] = last_idx[4:0];
                  word[10:5]  = last_idx;
                  word[4:0]   = last_idx[4:0];
                end
                default: begin
                  word[17:12] = last_idx;
                  word[11:6]  = last_idx;
                  word[5:0]   = last_idx;
                end
              endcase
            end
            send_request(CMD_CONVERT, word, tbl_idx_t'($urandom), 24'($urandom), no_hint);
            last_write = 1'b0;
          end
          sent++;
        end
        if (!steady) begin
          hold_off($urandom_range(1, 8));
        end
      end
    end

    wait_for_results();
    $display("covered %0d converts and %0d table writes; %0d pixels checked",
             convert_count, write_count, result_count);
    $display("pixel formats exercised: 12bpp=%0d 16bpp=%0d 18bpp=%0d 24bpp=%0d",
             formats_seen[FMT_12BPP], formats_seen[FMT_16BPP],
             formats_seen[FMT_18BPP], formats_seen[FMT_24BPP]);
    if (fail_count == 0 && expected_rgb.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- packed_pixel_gamma_converter_unit.f -----
sv/ppgc_pkg.sv
sv/ppgc_ram.sv
sv/packed_pixel_gamma_converter_unit.sv
bench/testbench.sv
